>>> hdl/ldcm_pkg.sv
// ldcm_pkg: shared types, constants and fixed-point helpers for the
// lens distortion coordinate map unit
// no dependencies
package ldcm_pkg;

	localparam int AW = 6;
	localparam int DW = 64;
	localparam int PW = 72;

	localparam int SH_NORM = 20;
	localparam int SH_COEF = 24;
	localparam int SH_UNIT = 28;

	typedef logic signed [PW-1:0] wide_t;

	localparam logic signed [31:0] FIX_MAX = 32'sh7FFFFFFF;
	localparam logic signed [31:0] FIX_MIN = -32'sh80000000;
	localparam logic signed [31:0] ONE_Q28 = 32'sh10000000;

	typedef struct packed {
		logic              sat;
		logic signed [31:0] val;
	} fix_t;

	typedef enum logic [2:0] {
		REG_NEW_CENTER,
		REG_NEW_INV_FOCAL,
		REG_SRC_FOCAL,
		REG_SRC_CENTER,
		REG_RADIAL_FIRST,
		REG_RADIAL_SECOND,
		REG_RADIAL_THIRD,
		REG_TANGENTIAL_PAIR
	} reg_t;

	function automatic fix_t clip(input wide_t v);
		fix_t r;
		if (v > wide_t'(FIX_MAX)) begin
			r.sat = 1'b1;
			r.val = FIX_MAX;
		end else if (v < wide_t'(FIX_MIN)) begin
			r.sat = 1'b1;
			r.val = FIX_MIN;
		end else begin
			r.sat = 1'b0;
			r.val = $signed(v[31:0]);
		end
		return r;
	endfunction

	// round half away from zero, then clip
	function automatic fix_t rnd_sat(input wide_t p, input int unsigned s);
		wide_t h;
		wide_t q;
		h = PW'(1) << (s - 1);
		q = (p + h - wide_t'(p[PW-1])) >>> s;
		return clip(q);
	endfunction

endpackage

>>> hdl/ldcm_if.sv
// ldcm_if: valid/ready channels of the lens distortion coordinate map unit
// pixel channel carries destination indices, coordinate channel the results
// no dependencies
interface ldcm_pix_if;
	logic        valid;
	logic        ready;
	logic [11:0] pixel_col;
	logic [11:0] pixel_row;

	modport source(output valid, output pixel_col, output pixel_row, input ready);
	modport sink(input valid, input pixel_col, input pixel_row, output ready);
endinterface

interface ldcm_src_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] source_col;
	logic signed [31:0] source_row;
	logic               saturated;

	modport source(output valid, output source_col, output source_row, output saturated,
		input ready);
	modport sink(input valid, input source_col, input source_row, input saturated,
		output ready);
endinterface

>>> hdl/lens_distortion_coordinate_map_unit.sv
// lens_distortion_coordinate_map_unit: Brown-Conrady undistortion map, top level
// depends on ldcm_pkg and the channel interfaces in ldcm_if.sv
//
// Usage: destination pixel indices (pixel_col, pixel_row) enter on the pixel
// channel; for each item the coord channel returns the source coordinate in
// signed Q16.16 plus a flag that is set when any value was clipped.
// Lens parameters sit in eight registers on the APB port at byte address 8*i
// (64-bit data, the three radial coefficients use the low 32 bits); write them
// only while no item is in flight.
// Pipeline: sixteen register stages; the result on coord is driven straight from
// the last stage (multiply and round/add stages mostly alternate; r^6 and the
// radial sum form the longest chain).
// Throughput: one item per cycle while coord is not stalled; every stage advances together.
// When coord is stalled with a result waiting, the whole pipeline holds and
// pixel.ready drops; nothing is lost or repeated.
// Reset clears the stage valid bits and the lens registers to zero; the data
// stages are not reset.
module lens_distortion_coordinate_map_unit #(
	parameter int MAX_DIM = 4096
) (
	input  logic                    clk,
	input  logic                    arst_n,
	ldcm_pix_if.sink                pixel,
	ldcm_src_if.source              coord,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [ldcm_pkg::AW-1:0] paddr,
	input  logic [ldcm_pkg::DW-1:0] pwdata,
	output logic [ldcm_pkg::DW-1:0] prdata,
	output logic                    pready
);
	import ldcm_pkg::*;

	localparam int NST = 16;
	localparam logic [16:0] DIM_LAST = 17'(MAX_DIM - 1);

	logic [63:0] new_center_q, new_inv_focal_q, src_focal_q, src_center_q, tangential_pair_q;
	logic [31:0] radial_first_q, radial_second_q, radial_third_q;
	reg_t        reg_idx;
	logic        en;
	logic [NST-1:0] vld_q;
	logic [11:0] col_c, row_c;

	logic signed [32:0] dx_s1, dy_s1;
	logic signed [65:0] pxn_s2, pyn_s2;
	logic signed [31:0] xn_s3, yn_s3, xn_s4, yn_s4, xn_s5, yn_s5, xn_s6, yn_s6;
	logic signed [31:0] xn_s7, yn_s7, xn_s8, yn_s8, xn_s9, yn_s9, xn_s10, yn_s10;
	logic signed [31:0] xn_s11, yn_s11, xn_s12, yn_s12;
	logic signed [63:0] pxx_s4, pyy_s4, pxy_s4;
	logic signed [31:0] x2_s5, y2_s5, xy_s5;
	logic signed [31:0] r2_s6, u_s6, v_s6, r2_s7, r2_s8;
	logic signed [32:0] tw_s6;
	logic signed [63:0] pr4_s7, pk1_s7, ptb_s7, pua_s7;
	logic signed [64:0] pta_s7, pub_s7;
	logic signed [31:0] r4_s8, k1r2_s8, k1r2_s9, k1r2_s10, k1r2_s11;
	logic signed [31:0] tx_s8, ty_s8, tx_s9, ty_s9, tx_s10, ty_s10, tx_s11, ty_s11;
	logic signed [31:0] tx_s12, ty_s12, tx_s13, ty_s13;
	logic signed [63:0] pr6_s9, pk2_s9, pk3_s11;
	logic signed [31:0] r6_s10, k2r4_s10, k2r4_s11, rad_s12;
	logic signed [63:0] pxd_s13, pyd_s13;
	logic signed [31:0] xd_s14, yd_s14;
	logic signed [64:0] psx_s15, psy_s15;
	logic signed [31:0] sx_s16, sy_s16;
	logic sat_s3, sat_s4, sat_s5, sat_s6, sat_s7, sat_s8, sat_s9, sat_s10;
	logic sat_s11, sat_s12, sat_s13, sat_s14, sat_s15, sat_s16;

	fix_t xn_c, yn_c, x2_c, y2_c, xy_c, r2_c, u_c, v_c;
	fix_t r4_c, k1r2_c, ta_c, tb_c, ua_c, ub_c, tx_c, ty_c;
	fix_t r6_c, k2r4_c, k3r6_c, rad_c, xr_c, yr_c, xd_c, yd_c, sxp_c, syp_c, sx_c, sy_c;

	// configuration port
	assign pready  = 1'b1;
	assign reg_idx = reg_t'(paddr[AW-1:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			new_center_q      <= '0;
			new_inv_focal_q   <= '0;
			src_focal_q       <= '0;
			src_center_q      <= '0;
			radial_first_q    <= '0;
			radial_second_q   <= '0;
			radial_third_q    <= '0;
			tangential_pair_q <= '0;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_idx)
				REG_NEW_CENTER:      new_center_q      <= pwdata;
				REG_NEW_INV_FOCAL:   new_inv_focal_q   <= pwdata;
				REG_SRC_FOCAL:       src_focal_q       <= pwdata;
				REG_SRC_CENTER:      src_center_q      <= pwdata;
				REG_RADIAL_FIRST:    radial_first_q    <= pwdata[31:0];
				REG_RADIAL_SECOND:   radial_second_q   <= pwdata[31:0];
				REG_RADIAL_THIRD:    radial_third_q    <= pwdata[31:0];
				REG_TANGENTIAL_PAIR: tangential_pair_q <= pwdata;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_NEW_CENTER:      prdata = new_center_q;
			REG_NEW_INV_FOCAL:   prdata = new_inv_focal_q;
			REG_SRC_FOCAL:       prdata = src_focal_q;
			REG_SRC_CENTER:      prdata = src_center_q;
			REG_RADIAL_FIRST:    prdata = DW'(radial_first_q);
			REG_RADIAL_SECOND:   prdata = DW'(radial_second_q);
			REG_RADIAL_THIRD:    prdata = DW'(radial_third_q);
			REG_TANGENTIAL_PAIR: prdata = tangential_pair_q;
		endcase
	end

	// handshake and stage valid bits
	assign en          = !vld_q[NST-1] || coord.ready;
	assign pixel.ready = en;
	assign coord.valid = vld_q[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NST-2:0], pixel.valid};
		end
	end

	// index clamp
	assign col_c = ({5'b0, pixel.pixel_col} > DIM_LAST) ? DIM_LAST[11:0] : pixel.pixel_col;
	assign row_c = ({5'b0, pixel.pixel_row} > DIM_LAST) ? DIM_LAST[11:0] : pixel.pixel_row;

	always_comb begin
		xn_c   = rnd_sat(wide_t'(pxn_s2), SH_NORM);
		yn_c   = rnd_sat(wide_t'(pyn_s2), SH_NORM);
		x2_c   = rnd_sat(wide_t'(pxx_s4), SH_UNIT);
		y2_c   = rnd_sat(wide_t'(pyy_s4), SH_UNIT);
		xy_c   = rnd_sat(wide_t'(pxy_s4), SH_UNIT);
		r2_c   = clip(wide_t'(x2_s5) + wide_t'(y2_s5));
		u_c    = clip((wide_t'(x2_s5) <<< 1) + wide_t'(x2_s5) + wide_t'(y2_s5));
		v_c    = clip((wide_t'(y2_s5) <<< 1) + wide_t'(y2_s5) + wide_t'(x2_s5));
		r4_c   = rnd_sat(wide_t'(pr4_s7), SH_UNIT);
		k1r2_c = rnd_sat(wide_t'(pk1_s7), SH_COEF);
		ta_c   = rnd_sat(wide_t'(pta_s7), SH_COEF);
		tb_c   = rnd_sat(wide_t'(ptb_s7), SH_COEF);
		ua_c   = rnd_sat(wide_t'(pua_s7), SH_COEF);
		ub_c   = rnd_sat(wide_t'(pub_s7), SH_COEF);
		tx_c   = clip(wide_t'(ta_c.val) + wide_t'(tb_c.val));
		ty_c   = clip(wide_t'(ua_c.val) + wide_t'(ub_c.val));
		r6_c   = rnd_sat(wide_t'(pr6_s9), SH_UNIT);
		k2r4_c = rnd_sat(wide_t'(pk2_s9), SH_COEF);
		k3r6_c = rnd_sat(wide_t'(pk3_s11), SH_COEF);
		rad_c  = clip(wide_t'(ONE_Q28) + wide_t'(k1r2_s11) + wide_t'(k2r4_s11)
			+ wide_t'(k3r6_c.val));
		xr_c   = rnd_sat(wide_t'(pxd_s13), SH_UNIT);
		yr_c   = rnd_sat(wide_t'(pyd_s13), SH_UNIT);
		xd_c   = clip(wide_t'(xr_c.val) + wide_t'(tx_s13));
		yd_c   = clip(wide_t'(yr_c.val) + wide_t'(ty_s13));
		sxp_c  = rnd_sat(wide_t'(psx_s15), SH_UNIT);
		syp_c  = rnd_sat(wide_t'(psy_s15), SH_UNIT);
		sx_c   = clip(wide_t'(sxp_c.val) + wide_t'($signed(src_center_q[31:0])));
		sy_c   = clip(wide_t'(syp_c.val) + wide_t'($signed(src_center_q[63:32])));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// normalize
			dx_s1  <= $signed({5'b0, col_c, 16'b0}) - $signed({new_center_q[31], new_center_q[31:0]});
			dy_s1  <= $signed({5'b0, row_c, 16'b0}) - $signed({new_center_q[63], new_center_q[63:32]});
			pxn_s2 <= dx_s1 * $signed({1'b0, new_inv_focal_q[31:0]});
			pyn_s2 <= dy_s1 * $signed({1'b0, new_inv_focal_q[63:32]});
			xn_s3  <= xn_c.val;
			yn_s3  <= yn_c.val;
			sat_s3 <= xn_c.sat | yn_c.sat;
			// squares
			pxx_s4 <= xn_s3 * xn_s3;
			pyy_s4 <= yn_s3 * yn_s3;
			pxy_s4 <= xn_s3 * yn_s3;
			xn_s4  <= xn_s3;
			yn_s4  <= yn_s3;
			sat_s4 <= sat_s3;
			x2_s5  <= x2_c.val;
			y2_s5  <= y2_c.val;
			xy_s5  <= xy_c.val;
			xn_s5  <= xn_s4;
			yn_s5  <= yn_s4;
			sat_s5 <= sat_s4 | x2_c.sat | y2_c.sat | xy_c.sat;
			r2_s6  <= r2_c.val;
			u_s6   <= u_c.val;
			v_s6   <= v_c.val;
			tw_s6  <= $signed({xy_s5, 1'b0});
			xn_s6  <= xn_s5;
			yn_s6  <= yn_s5;
			sat_s6 <= sat_s5 | r2_c.sat | u_c.sat | v_c.sat;
			// r^4, k1 term, tangential
			pr4_s7 <= r2_s6 * r2_s6;
			pk1_s7 <= $signed(radial_first_q) * r2_s6;
			pta_s7 <= $signed(tangential_pair_q[31:0]) * tw_s6;
			ptb_s7 <= $signed(tangential_pair_q[63:32]) * u_s6;
			pua_s7 <= $signed(tangential_pair_q[31:0]) * v_s6;
			pub_s7 <= $signed(tangential_pair_q[63:32]) * tw_s6;
			r2_s7  <= r2_s6;
			xn_s7  <= xn_s6;
			yn_s7  <= yn_s6;
			sat_s7 <= sat_s6;
			r4_s8   <= r4_c.val;
			k1r2_s8 <= k1r2_c.val;
			tx_s8   <= tx_c.val;
			ty_s8   <= ty_c.val;
			r2_s8   <= r2_s7;
			xn_s8   <= xn_s7;
			yn_s8   <= yn_s7;
			sat_s8  <= sat_s7 | r4_c.sat | k1r2_c.sat | ta_c.sat | tb_c.sat | ua_c.sat
				| ub_c.sat | tx_c.sat | ty_c.sat;
			// r^6, k2 term
			pr6_s9  <= r4_s8 * r2_s8;
			pk2_s9  <= $signed(radial_second_q) * r4_s8;
			k1r2_s9 <= k1r2_s8;
			tx_s9   <= tx_s8;
			ty_s9   <= ty_s8;
			xn_s9   <= xn_s8;
			yn_s9   <= yn_s8;
			sat_s9  <= sat_s8;
			r6_s10   <= r6_c.val;
			k2r4_s10 <= k2r4_c.val;
			k1r2_s10 <= k1r2_s9;
			tx_s10   <= tx_s9;
			ty_s10   <= ty_s9;
			xn_s10   <= xn_s9;
			yn_s10   <= yn_s9;
			sat_s10  <= sat_s9 | r6_c.sat | k2r4_c.sat;
			// k3 term, radial factor
			pk3_s11  <= $signed(radial_third_q) * r6_s10;
			k1r2_s11 <= k1r2_s10;
			k2r4_s11 <= k2r4_s10;
			tx_s11   <= tx_s10;
			ty_s11   <= ty_s10;
			xn_s11   <= xn_s10;
			yn_s11   <= yn_s10;
			sat_s11  <= sat_s10;
			rad_s12  <= rad_c.val;
			tx_s12   <= tx_s11;
			ty_s12   <= ty_s11;
			xn_s12   <= xn_s11;
			yn_s12   <= yn_s11;
			sat_s12  <= sat_s11 | k3r6_c.sat | rad_c.sat;
			// distorted point
			pxd_s13 <= xn_s12 * rad_s12;
			pyd_s13 <= yn_s12 * rad_s12;
			tx_s13  <= tx_s12;
			ty_s13  <= ty_s12;
			sat_s13 <= sat_s12;
			xd_s14  <= xd_c.val;
			yd_s14  <= yd_c.val;
			sat_s14 <= sat_s13 | xr_c.sat | yr_c.sat | xd_c.sat | yd_c.sat;
			// projection
			psx_s15 <= $signed({1'b0, src_focal_q[31:0]}) * xd_s14;
			psy_s15 <= $signed({1'b0, src_focal_q[63:32]}) * yd_s14;
			sat_s15 <= sat_s14;
			sx_s16  <= sx_c.val;
			sy_s16  <= sy_c.val;
			sat_s16 <= sat_s15 | sxp_c.sat | syp_c.sat | sx_c.sat | sy_c.sat;
		end
	end

	assign coord.source_col = sx_s16;
	assign coord.source_row = sy_s16;
	assign coord.saturated  = sat_s16;

	// stalled pipeline holds every stage
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("stage valid bits moved during stall");

	// input side only blocks behind a waiting result
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!pixel.ready |-> coord.valid)
		else $error("pixel channel blocked with no result waiting");

	// a result comes from the stage before or was already waiting
	a_out_origin: assert property (@(posedge clk) disable iff (!arst_n)
		coord.valid |-> $past(vld_q[NST-2]) || $past(coord.valid))
		else $error("result appeared without a source stage");

endmodule

>>> tb/sv/lens_distortion_coordinate_map_unit_tb.sv
// lens_distortion_coordinate_map_unit_tb: self-checking bench for the Brown-Conrady map unit
// drives pixel items and lens registers, predicts each source coordinate in fixed point
// depends on ldcm_pkg, ldcm_if.sv and lens_distortion_coordinate_map_unit
module lens_distortion_coordinate_map_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ldcm_pkg::*;

	localparam int MAX_DIM = 4096;
	localparam int LATENCY = 16;

	typedef struct packed {
		logic signed [31:0] source_col;
		logic signed [31:0] source_row;
		logic               saturated;
	} coord_t;

	logic          clk = 1'b0;
	logic          arst_n;
	logic          psel;
	logic          penable;
	logic          pwrite;
	logic [AW-1:0] paddr;
	logic [DW-1:0] pwdata;
	logic [DW-1:0] prdata;
	logic          pready;

	ldcm_pix_if pix_ch();
	ldcm_src_if crd_ch();

	lens_distortion_coordinate_map_unit #(
		.MAX_DIM (MAX_DIM)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.pixel   (pix_ch),
		.coord   (crd_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #5 clk = ~clk;

	logic [63:0] lens_regs [8];
	coord_t      coord_due [$];
	bit          pred_sat;
	int          errors;
	int          items_sent;
	int          results_checked;
	int          results_flagged;
	int          reg_writes;
	int          hold_cycles;
	int          gap_pct;
	int          stall_pct;

	function automatic longint as_signed(logic [31:0] w);
		return longint'($signed(w));
	endfunction

	function automatic longint sat_word(longint v);
		if (v > 64'sh7FFF_FFFF) begin
			pred_sat = 1'b1;
			return 64'sh7FFF_FFFF;
		end
		if (v < -64'sh8000_0000) begin
			pred_sat = 1'b1;
			return -64'sh8000_0000;
		end
		return v;
	endfunction

	// exact product, shifted down with round half away from zero, then clipped
	function automatic longint scaled_product(longint a, longint b, int unsigned s);
		logic signed [127:0] wa;
		logic signed [127:0] wb;
		logic signed [127:0] p;
		logic [127:0]        q;
		bit                  neg;
		wa = a;
		wb = b;
		p = wa * wb;
		neg = p < 0;
		q = neg ? -p : p;
		q = (q + (128'd1 << (s - 1))) >> s;
		if (neg) begin
			if (q > 128'h8000_0000) begin
				pred_sat = 1'b1;
				q = 128'h8000_0000;
			end
			return -longint'(q[63:0]);
		end
		if (q > 128'h7FFF_FFFF) begin
			pred_sat = 1'b1;
			q = 128'h7FFF_FFFF;
		end
		return longint'(q[63:0]);
	endfunction

	function automatic coord_t predict_source_coord(logic [11:0] pc, logic [11:0] pr);
		longint col, row, dx, dy, xn, yn, x2, y2, xy, r2, r4, r6, rad;
		longint tx, ty, xd, yd, sx, sy, k1, k2, k3, p1, p2;
		coord_t res;
		pred_sat = 1'b0;
		col = pc;
		row = pr;
		if (col >= MAX_DIM) col = MAX_DIM - 1;
		if (row >= MAX_DIM) row = MAX_DIM - 1;
		k1 = as_signed(lens_regs[REG_RADIAL_FIRST][31:0]);
		k2 = as_signed(lens_regs[REG_RADIAL_SECOND][31:0]);
		k3 = as_signed(lens_regs[REG_RADIAL_THIRD][31:0]);
		p1 = as_signed(lens_regs[REG_TANGENTIAL_PAIR][31:0]);
		p2 = as_signed(lens_regs[REG_TANGENTIAL_PAIR][63:32]);

		dx = (col <<< 16) - as_signed(lens_regs[REG_NEW_CENTER][31:0]);
		dy = (row <<< 16) - as_signed(lens_regs[REG_NEW_CENTER][63:32]);
		xn = scaled_product(dx, longint'(lens_regs[REG_NEW_INV_FOCAL][31:0]), SH_NORM);
		yn = scaled_product(dy, longint'(lens_regs[REG_NEW_INV_FOCAL][63:32]), SH_NORM);

		x2 = scaled_product(xn, xn, SH_UNIT);
		y2 = scaled_product(yn, yn, SH_UNIT);
		xy = scaled_product(xn, yn, SH_UNIT);
		r2 = sat_word(x2 + y2);
		r4 = scaled_product(r2, r2, SH_UNIT);
		r6 = scaled_product(r4, r2, SH_UNIT);

		rad = sat_word(longint'(ONE_Q28) + scaled_product(k1, r2, SH_COEF)
			+ scaled_product(k2, r4, SH_COEF) + scaled_product(k3, r6, SH_COEF));
		tx = sat_word(scaled_product(p1, 2 * xy, SH_COEF)
			+ scaled_product(p2, sat_word(r2 + 2 * x2), SH_COEF));
		ty = sat_word(scaled_product(p1, sat_word(r2 + 2 * y2), SH_COEF)
			+ scaled_product(p2, 2 * xy, SH_COEF));

		xd = sat_word(scaled_product(xn, rad, SH_UNIT) + tx);
		yd = sat_word(scaled_product(yn, rad, SH_UNIT) + ty);

		sx = sat_word(scaled_product(longint'(lens_regs[REG_SRC_FOCAL][31:0]), xd, SH_UNIT)
			+ as_signed(lens_regs[REG_SRC_CENTER][31:0]));
		sy = sat_word(scaled_product(longint'(lens_regs[REG_SRC_FOCAL][63:32]), yd, SH_UNIT)
			+ as_signed(lens_regs[REG_SRC_CENTER][63:32]));

		res.source_col = sx[31:0];
		res.source_row = sy[31:0];
		res.saturated = pred_sat;
		return res;
	endfunction

	function automatic logic [63:0] pack_pair(int lo, int hi);
		return {hi, lo};
	endfunction

	function automatic logic [31:0] rand_center();
		return {4'b0, 12'($urandom), 16'($urandom)};
	endfunction

	always @(posedge clk) begin : coord_rx
		coord_t want;
		if (arst_n && crd_ch.valid && crd_ch.ready) begin
			if (coord_due.size() == 0) begin
				$error("coord item arrived with no pixel item pending");
				errors++;
			end else begin
				want = coord_due.pop_front();
				results_checked++;
				if (crd_ch.saturated === 1'b1) results_flagged++;
				if (crd_ch.source_col !== want.source_col) begin
					$error("source_col: expected %0d, got %0d", want.source_col,
						crd_ch.source_col);
					errors++;
				end
				if (crd_ch.source_row !== want.source_row) begin
					$error("source_row: expected %0d, got %0d", want.source_row,
						crd_ch.source_row);
					errors++;
				end
				if (crd_ch.saturated !== want.saturated) begin
					$error("saturated: expected %0b, got %0b", want.saturated,
						crd_ch.saturated);
					errors++;
				end
			end
		end
		if (hold_cycles != 0) begin
			hold_cycles--;
			crd_ch.ready <= 1'b0;
		end else begin
			crd_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic set_idle(int phase);
		case (phase)
			0: begin
				gap_pct = 0;
				stall_pct = 0;
			end
			1: begin
				gap_pct = 85;
				stall_pct = 0;
			end
			2: begin
				gap_pct = 0;
				stall_pct = 85;
			end
			default: begin
				gap_pct = 28;
				stall_pct = 28;
			end
		endcase
	endtask

	task automatic write_lens_reg(reg_t idx, logic [63:0] val);
		if (idx == REG_RADIAL_FIRST || idx == REG_RADIAL_SECOND || idx == REG_RADIAL_THIRD)
			lens_regs[idx] = {32'b0, val[31:0]};
		else
			lens_regs[idx] = val;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		reg_writes++;
	endtask

	task automatic send_pixel(logic [11:0] c, logic [11:0] r);
		while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
			pix_ch.valid <= 1'b0;
			@(posedge clk);
		end
		pix_ch.valid <= 1'b1;
		pix_ch.pixel_col <= c;
		pix_ch.pixel_row <= r;
		@(posedge clk);
		while (!pix_ch.ready) @(posedge clk);
		coord_due = {coord_due, predict_source_coord(c, r)};
		items_sent++;
	endtask

	task automatic drain_pipeline();
		pix_ch.valid <= 1'b0;
		while (coord_due.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic load_plausible_lens();
		int unsigned fx, fy;
		int k1, k2, k3, p1, p2;
		fx = $urandom_range(4000, 1200);
		fy = fx + $urandom_range(40);
		k1 = int'($urandom_range(1 << 24)) - (1 << 23);
		k2 = int'($urandom_range(1 << 23)) - (1 << 22);
		k3 = int'($urandom_range(1 << 22)) - (1 << 21);
		p1 = int'($urandom_range(168000)) - 84000;
		p2 = int'($urandom_range(168000)) - 84000;
		write_lens_reg(REG_NEW_CENTER, {rand_center(), rand_center()});
		write_lens_reg(REG_NEW_INV_FOCAL,
			{32'(64'h1_0000_0000 / fy), 32'(64'h1_0000_0000 / fx)});
		write_lens_reg(REG_SRC_FOCAL, {fy[15:0], 16'($urandom), fx[15:0], 16'($urandom)});
		write_lens_reg(REG_SRC_CENTER, {rand_center(), rand_center()});
		write_lens_reg(REG_RADIAL_FIRST, {32'($urandom), k1});
		write_lens_reg(REG_RADIAL_SECOND, {32'($urandom), k2});
		write_lens_reg(REG_RADIAL_THIRD, {32'($urandom), k3});
		write_lens_reg(REG_TANGENTIAL_PAIR, pack_pair(p1, p2));
	endtask

	task automatic load_random_lens();
		for (int i = 0; i < 8; i++) write_lens_reg(reg_t'(i), {$urandom, $urandom});
	endtask

	task automatic test_reset_state();
		drain_pipeline();
		set_idle(0);
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd4095, 12'd4095);
		send_pixel(12'hAAA, 12'h555);
	endtask

	task automatic test_plain_pinhole();
		drain_pipeline();
		write_lens_reg(REG_NEW_CENTER, pack_pair(32'h0800_0000, 32'h0600_0000));
		write_lens_reg(REG_NEW_INV_FOCAL, pack_pair(2147484, 2147484));
		write_lens_reg(REG_SRC_FOCAL, pack_pair(32'h07D0_0000, 32'h07D0_0000));
		write_lens_reg(REG_SRC_CENTER, pack_pair(32'h0800_0000, 32'h0600_0000));
		write_lens_reg(REG_RADIAL_FIRST, 64'd0);
		write_lens_reg(REG_RADIAL_SECOND, 64'd0);
		write_lens_reg(REG_RADIAL_THIRD, 64'd0);
		write_lens_reg(REG_TANGENTIAL_PAIR, 64'd0);
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd4095, 12'd0);
		send_pixel(12'd0, 12'd4095);
		send_pixel(12'd2048, 12'd1536);
	endtask

	task automatic test_barrel_lens();
		drain_pipeline();
		write_lens_reg(REG_RADIAL_FIRST, pack_pair(-4194304, 0));
		write_lens_reg(REG_RADIAL_SECOND, pack_pair(838861, 0));
		write_lens_reg(REG_RADIAL_THIRD, pack_pair(-167772, 0));
		write_lens_reg(REG_TANGENTIAL_PAIR, pack_pair(16777, -16777));
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd4095, 12'd4095);
		send_pixel(12'd1024, 12'd768);
		send_pixel(12'd3000, 12'd200);
		send_pixel(12'd2048, 12'd1536);
	endtask

	task automatic test_zero_src_focal();
		drain_pipeline();
		write_lens_reg(REG_SRC_FOCAL, 64'd0);
		write_lens_reg(REG_SRC_CENTER, pack_pair(19088743, -16711680));
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd4095, 12'd17);
		send_pixel(12'd2048, 12'd1536);
	endtask

	task automatic test_register_extremes();
		logic [63:0] fills [3];
		fills[0] = 64'hFFFF_FFFF_FFFF_FFFF;
		fills[1] = 64'h7FFF_FFFF_7FFF_FFFF;
		fills[2] = 64'h8000_0000_8000_0000;
		for (int f = 0; f < 3; f++) begin
			drain_pipeline();
			for (int i = 0; i < 8; i++) write_lens_reg(reg_t'(i), fills[f]);
			send_pixel(12'd0, 12'd0);
			send_pixel(12'd4095, 12'd4095);
		end
	endtask

	task automatic test_backpressure();
		drain_pipeline();
		load_plausible_lens();
		set_idle(0);
		hold_cycles = 300;
		repeat (60) send_pixel(12'($urandom), 12'($urandom));
	endtask

	task automatic test_random_lenses();
		for (int k = 0; k < 8; k++) begin
			drain_pipeline();
			if (k % 2 == 0)
				load_plausible_lens();
			else
				load_random_lens();
			set_idle((k / 2) % 4);
			repeat (160) send_pixel(12'($urandom), 12'($urandom));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		pix_ch.valid = 1'b0;
		pix_ch.pixel_col = '0;
		pix_ch.pixel_row = '0;
		hold_cycles = 0;
		gap_pct = 0;
		stall_pct = 0;
		for (int i = 0; i < 8; i++) lens_regs[i] = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_plain_pinhole();
		test_barrel_lens();
		test_zero_src_focal();
		test_register_extremes();
		test_backpressure();
		test_random_lenses();

		pix_ch.valid <= 1'b0;
		for (int n = 0; n < 100000 && coord_due.size() != 0; n++) @(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);
		if (coord_due.size() != 0) begin
			$error("%0d expected coord items never arrived", coord_due.size());
			errors++;
		end
		$display("checked %0d of %0d pixel items, %0d with the clip flag set",
			results_checked, items_sent, results_flagged);
		$display("%0d register writes over reset, pinhole, barrel, extreme and random lenses",
			reg_writes);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

>>> files.f
hdl/ldcm_pkg.sv
hdl/ldcm_if.sv
hdl/lens_distortion_coordinate_map_unit.sv
tb/sv/lens_distortion_coordinate_map_unit_tb.sv
